// File: rtl/tomseq_pkg.sv
// shared types and codes for the total-order multicast sequencer
package tomseq_pkg;

  typedef enum logic [1:0] {
    MODE_SEND = 2'd0,
    MODE_DATA = 2'd1,
    MODE_ACK  = 2'd2,
    MODE_SEQ  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    KIND_DATA  = 3'd0,
    KIND_ACK   = 3'd1,
    KIND_FINAL = 3'd2,
    KIND_DELIV = 3'd3,
    KIND_FULL  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  localparam logic CFG_OWN_ID = 1'b0;
  localparam logic CFG_HOSTS  = 1'b1;

  localparam logic [4:0] MAX_DELIVERIES = 5'd16;
  localparam logic [7:0] ACK_SAT        = 8'd255;

  typedef struct packed {
    logic [7:0]  sender;
    logic [31:0] msg_id;
    logic [31:0] payload;
    logic [7:0]  ack_count;
    logic [31:0] fin_seq;
    logic [7:0]  proposer;
    logic        ready;
  } entry_t;

endpackage

// File: rtl/tomseq_table.sv
// pending message table: one write port, one registered read port
module tomseq_table #(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  tomseq_pkg::entry_t         wr_data,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output tomseq_pkg::entry_t         rd_data
);
  import tomseq_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;
endmodule

// File: rtl/total_order_multicast_sequencer.sv
// total-order multicast sequencer top level
// local send and data arrival: one result in the cycle after the start transfer, busy stays low
// ack events: scan the table one entry a cycle from slot 0, busy until the scan reaches
// the last filled slot, ending at the first match; sequence events: busy while the scan covers
// every filled slot and then for one flush state; an empty table keeps busy low
// results leave on a one-cycle strobe; the receiver cannot stall; synchronous active-low reset
module total_order_multicast_sequencer #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_src_process,
  input  logic [31:0] in_message_id,
  input  logic [31:0] in_payload,
  input  logic [31:0] in_seq_number,
  input  logic [7:0]  in_seq_proposer,
  output logic        out_strobe,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_dest_process,
  output logic [7:0]  out_sender,
  output logic [31:0] out_message_id,
  output logic [31:0] out_payload,
  output logic [31:0] out_seq,
  output logic [7:0]  out_proposer,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  import tomseq_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH);

  state_t state_r, state_nxt;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] wr_r, wr_nxt;
  logic [4:0]    ndel_r, ndel_nxt;
  mode_t         mode_r;
  logic [31:0]   id_r, seq_r;
  logic [7:0]    prop_r;
  logic [31:0]   next_id_r, next_id_nxt;
  logic [31:0]   last_seq_r, last_seq_nxt;
  logic [7:0]    own_r, hosts_r;

  logic          pend_vld_r, pend_vld_nxt;
  entry_t        pend_r, pend_nxt;

  logic          strobe_nxt, last_nxt;
  logic [2:0]    kind_nxt;
  logic [7:0]    dest_nxt, sender_nxt, prop_out_nxt;
  logic [31:0]   id_out_nxt, pay_nxt, seq_out_nxt;

  logic          strobe_r, last_r;
  logic [2:0]    kind_r;
  logic [7:0]    dest_r, sender_r, prop_out_r;
  logic [31:0]   id_out_r, pay_r, seq_out_r;

  logic          mem_we;
  logic [IW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata, rd_e, upd_e;

  logic          accept, end_scan, match, lower, deliver, inc;
  logic [7:0]    new_ack;

  assign accept   = start && (state_r == ST_IDLE);
  assign busy     = (state_r != ST_IDLE);
  assign end_scan = ({1'b0, pos_r} + (IW+1)'(1)) == (IW+1)'(cnt_r);
  assign match    = (rd_e.msg_id == id_r);
  assign lower    = rd_e.ready && (rd_e.fin_seq < seq_r);
  assign deliver  = lower && (ndel_r < MAX_DELIVERIES);
  assign inc      = (rd_e.ack_count < ACK_SAT);
  assign new_ack  = rd_e.ack_count + {7'd0, inc};
  assign mem_raddr = (state_r == ST_SCAN) ? pos_r + IW'(1) : '0;

  tomseq_table #(.DEPTH(TABLE_DEPTH)) u_table (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (rd_e)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_mode == MODE_ACK || in_mode == MODE_SEQ) && cnt_r != '0) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (mode_r == MODE_ACK) begin
          if (match || end_scan) state_nxt = ST_IDLE;
        end else if (end_scan) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath and results
  always_comb begin
    cnt_nxt      = cnt_r;
    pos_nxt      = pos_r;
    wr_nxt       = wr_r;
    ndel_nxt     = ndel_r;
    next_id_nxt  = next_id_r;
    last_seq_nxt = last_seq_r;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = rd_e;
    upd_e        = rd_e;
    strobe_nxt   = 1'b0;
    last_nxt     = 1'b0;
    kind_nxt     = KIND_DATA;
    dest_nxt     = '0;
    sender_nxt   = '0;
    id_out_nxt   = '0;
    pay_nxt      = '0;
    seq_out_nxt  = '0;
    prop_out_nxt = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          pos_nxt      = '0;
          wr_nxt       = '0;
          ndel_nxt     = '0;
          pend_vld_nxt = 1'b0;
          unique case (mode_t'(in_mode))
            MODE_SEND: begin
              strobe_nxt  = 1'b1;
              last_nxt    = 1'b1;
              kind_nxt    = KIND_DATA;
              sender_nxt  = own_r;
              id_out_nxt  = next_id_r;
              pay_nxt     = in_payload;
              next_id_nxt = next_id_r + 32'd1;
            end
            MODE_DATA: begin
              strobe_nxt = 1'b1;
              last_nxt   = 1'b1;
              sender_nxt = in_src_process;
              id_out_nxt = in_message_id;
              if (cnt_r == FULL_CNT) begin
                kind_nxt = KIND_FULL;
                pay_nxt  = in_payload;
              end else begin
                mem_we              = 1'b1;
                mem_waddr           = cnt_r[IW-1:0];
                mem_wdata.sender    = in_src_process;
                mem_wdata.msg_id    = in_message_id;
                mem_wdata.payload   = in_payload;
                mem_wdata.ack_count = '0;
                mem_wdata.fin_seq   = '0;
                mem_wdata.proposer  = '0;
                mem_wdata.ready     = 1'b0;
                cnt_nxt             = cnt_r + CW'(1);
                if (in_message_id > next_id_r) next_id_nxt = in_message_id;
                kind_nxt     = KIND_ACK;
                dest_nxt     = in_src_process;
                seq_out_nxt  = last_seq_r + 32'd1;
                prop_out_nxt = own_r;
              end
            end
            MODE_ACK: ;
            MODE_SEQ: begin
              if (cnt_r == '0) last_seq_nxt = in_seq_number;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        pos_nxt = pos_r + IW'(1);
        if (mode_r == MODE_ACK) begin
          if (match) begin
            upd_e.ack_count = new_ack;
            if (seq_r > rd_e.fin_seq) begin
              upd_e.fin_seq  = seq_r;
              upd_e.proposer = prop_r;
            end
            mem_we    = 1'b1;
            mem_waddr = pos_r;
            mem_wdata = upd_e;
            if (inc && new_ack == hosts_r) begin
              strobe_nxt   = 1'b1;
              last_nxt     = 1'b1;
              kind_nxt     = KIND_FINAL;
              sender_nxt   = rd_e.sender;
              id_out_nxt   = rd_e.msg_id;
              seq_out_nxt  = upd_e.fin_seq;
              prop_out_nxt = own_r;
            end
          end
        end else begin
          if (deliver) begin
            if (pend_vld_r) begin
              strobe_nxt   = 1'b1;
              kind_nxt     = KIND_DELIV;
              sender_nxt   = pend_r.sender;
              id_out_nxt   = pend_r.msg_id;
              pay_nxt      = pend_r.payload;
              seq_out_nxt  = pend_r.fin_seq;
              prop_out_nxt = pend_r.proposer;
            end
            pend_vld_nxt = 1'b1;
            pend_nxt     = rd_e;
            ndel_nxt     = ndel_r + 5'd1;
          end else begin
            if (match && !lower) begin
              upd_e.ready    = 1'b1;
              upd_e.fin_seq  = seq_r;
              upd_e.proposer = prop_r;
            end
            mem_we    = 1'b1;
            mem_waddr = wr_r[IW-1:0];
            mem_wdata = upd_e;
            wr_nxt    = wr_r + CW'(1);
          end
          if (end_scan) begin
            cnt_nxt      = wr_nxt;
            last_seq_nxt = seq_r;
          end
        end
      end
      ST_FLUSH: begin
        if (pend_vld_r) begin
          strobe_nxt   = 1'b1;
          last_nxt     = 1'b1;
          kind_nxt     = KIND_DELIV;
          sender_nxt   = pend_r.sender;
          id_out_nxt   = pend_r.msg_id;
          pay_nxt      = pend_r.payload;
          seq_out_nxt  = pend_r.fin_seq;
          prop_out_nxt = pend_r.proposer;
        end
        pend_vld_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cnt_r      <= '0;
      next_id_r  <= '0;
      last_seq_r <= '0;
      own_r      <= 8'd0;
      hosts_r    <= 8'd1;
      pend_vld_r <= 1'b0;
      strobe_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      next_id_r  <= next_id_nxt;
      last_seq_r <= last_seq_nxt;
      pend_vld_r <= pend_vld_nxt;
      strobe_r   <= strobe_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_OWN_ID: own_r   <= cfg_data;
          CFG_HOSTS:  hosts_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    wr_r       <= wr_nxt;
    ndel_r     <= ndel_nxt;
    pend_r     <= pend_nxt;
    last_r     <= last_nxt;
    kind_r     <= kind_nxt;
    dest_r     <= dest_nxt;
    sender_r   <= sender_nxt;
    id_out_r   <= id_out_nxt;
    pay_r      <= pay_nxt;
    seq_out_r  <= seq_out_nxt;
    prop_out_r <= prop_out_nxt;
    if (accept) begin
      mode_r <= mode_t'(in_mode);
      id_r   <= in_message_id;
      seq_r  <= in_seq_number;
      prop_r <= in_seq_proposer;
    end
  end

  assign out_strobe       = strobe_r;
  assign out_kind         = kind_r;
  assign out_dest_process = dest_r;
  assign out_sender       = sender_r;
  assign out_message_id   = id_out_r;
  assign out_payload      = pay_r;
  assign out_seq          = seq_out_r;
  assign out_proposer     = prop_out_r;
  assign out_last         = last_r;
endmodule
